// ===== hdl/sspq_pkg.sv =====
// Package with the shared widths, command codes, status codes and cell types.
package sspq_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int DATA_W = 32;
  localparam int CMD_W = 2;
  localparam int POS_W = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd3;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } cell_flags_t;

endpackage

// ===== hdl/sspq_cell.sv =====
// One storage cell of the sorted chain: compare against the word and shift.
module sspq_cell (
  input  logic                 clk,
  input  sspq_pkg::cell_op_t   op,
  input  sspq_pkg::data_t      value,
  input  logic                 valid,
  input  logic                 left_gt,
  input  sspq_pkg::data_t      left_entry,
  input  sspq_pkg::data_t      right_entry,
  output sspq_pkg::data_t      entry,
  output sspq_pkg::cell_flags_t flags
);

  sspq_pkg::data_t entry_next;

  always_comb begin
    flags.gt = valid && (entry > value);
    flags.eq = valid && (entry == value);
  end

  always_comb begin
    entry_next = entry;
    case (op)
      sspq_pkg::CELL_INSERT: begin
        if (!flags.gt) begin
          entry_next = left_gt ? value : left_entry;
        end
      end
      sspq_pkg::CELL_DELETE: begin
        if (!flags.gt) begin
          entry_next = right_entry;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== hdl/sorted_set_priority_queue_unit.sv =====
// Top level of the sorted-set priority queue built from a chain of cells.
//
//   channel   signals                                   handshake
//   command   cmd, value                                start, busy
//   result    found, position, status, count,           done
//             empty_res, top_value
//
// A word is taken at the clock edge where start is high and busy is low.
// The cells compare and shift in the following cycle, and done is a one-cycle
// strobe after that, with busy already low again. No new word is
// taken while busy is high during the compare-and-shift through the cell chain.
// Reset empties the store at once. The receiver takes every result word.
module sorted_set_priority_queue_unit #(
  parameter int CAPACITY = sspq_pkg::DEFAULT_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [sspq_pkg::CMD_W-1:0]       cmd,
  input  logic signed [sspq_pkg::DATA_W-1:0] value,
  output logic                             done,
  output logic                             found,
  output logic [sspq_pkg::POS_W-1:0]       position,
  output logic [sspq_pkg::STATUS_W-1:0]    status,
  output logic [sspq_pkg::COUNT_W-1:0]     count,
  output logic                             empty_res,
  output logic signed [sspq_pkg::DATA_W-1:0] top_value
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {
    PH_IDLE,
    PH_APPLY
  } phase_t;

  phase_t phase;
  logic [sspq_pkg::CMD_W-1:0] cur_cmd;
  sspq_pkg::data_t cur_value;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;

  sspq_pkg::data_t entries [CAPACITY];
  sspq_pkg::cell_flags_t flags [CAPACITY];
  logic [IDX_W-1:0] match_idx [CAPACITY];

  sspq_pkg::cell_op_t op;
  logic hit;
  logic [IDX_W-1:0] hit_idx;
  logic full;
  logic [sspq_pkg::STATUS_W-1:0] status_next;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic cell_valid;
    logic cell_left_gt;
    sspq_pkg::data_t cell_left;
    sspq_pkg::data_t cell_right;

    assign cell_valid = (CNT_W'(i) < fill);
    assign match_idx[i] = flags[i].eq ? IDX_W'(i) : '0;

    if (i == 0) begin : g_first
      assign cell_left_gt = 1'b1;
      assign cell_left = cur_value;
    end else begin : g_inner_left
      assign cell_left_gt = flags[i-1].gt;
      assign cell_left = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign cell_right = entries[i];
    end else begin : g_inner_right
      assign cell_right = entries[i+1];
    end

    sspq_cell u_cell (
      .clk         (clk),
      .op          (op),
      .value       (cur_value),
      .valid       (cell_valid),
      .left_gt     (cell_left_gt),
      .left_entry  (cell_left),
      .right_entry (cell_right),
      .entry       (entries[i]),
      .flags       (flags[i])
    );
  end

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit = hit | flags[i].eq;
      hit_idx = hit_idx | match_idx[i];
    end
  end

  assign full = (fill == CNT_W'(CAPACITY));

  always_comb begin
    op = sspq_pkg::CELL_HOLD;
    fill_next = fill;
    status_next = sspq_pkg::STATUS_DONE;
    case (cur_cmd)
      sspq_pkg::CMD_INSERT: begin
        if (hit) begin
          status_next = sspq_pkg::STATUS_DUPLICATE;
        end else if (full) begin
          status_next = sspq_pkg::STATUS_FULL;
        end else begin
          op = sspq_pkg::CELL_INSERT;
          fill_next = fill + 1'b1;
        end
      end
      sspq_pkg::CMD_DELETE: begin
        if (hit) begin
          op = sspq_pkg::CELL_DELETE;
          fill_next = fill - 1'b1;
        end else begin
          status_next = sspq_pkg::STATUS_NOT_FOUND;
        end
      end
      default: begin
        if (!hit) begin
          status_next = sspq_pkg::STATUS_NOT_FOUND;
        end
      end
    endcase
    if (phase != PH_APPLY) begin
      op = sspq_pkg::CELL_HOLD;
      fill_next = fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      fill <= '0;
      done <= 1'b0;
    end else begin
      fill <= fill_next;
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_APPLY;
          end
        end
        PH_APPLY: begin
          phase <= PH_IDLE;
          done <= 1'b1;
          found <= hit;
          position <= hit ? sspq_pkg::POS_W'(hit_idx) : '0;
          status <= status_next;
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase == PH_IDLE && start) begin
      cur_cmd <= cmd;
      cur_value <= value;
    end
  end

  assign busy = (phase == PH_APPLY);
  assign count = sspq_pkg::COUNT_W'(fill);
  assign empty_res = (fill == '0);
  assign top_value = (fill == '0) ? '0 : entries[0];

endmodule
